// ----- rtl/core/guillotine_atlas_allocator_defines.svh -----
// Assertion macros for the atlas allocator.
`ifndef GUILLOTINE_ATLAS_ALLOCATOR_DEFINES_SVH
`define GUILLOTINE_ATLAS_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define GAA_ASSERT_IMPL(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) cond) else $error(msg);
`define GAA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GAA_ASSERT_IMPL(lbl, cond, msg)
`define GAA_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/core/gaa_pkg.sv -----
package gaa_pkg;
    localparam int FreeSlots = 256;
    localparam int CoordBits = 13;
    localparam int IdxBits = $clog2(FreeSlots);
    localparam int CntBits = $clog2(FreeSlots + 1);
    localparam int QDepth = 2;
    localparam logic [CoordBits-1:0] AtlasMax = CoordBits'(4096);
    localparam logic [CoordBits-1:0] AtlasReset = CoordBits'(1024);

    localparam logic [1:0] STAT_PLACED = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    localparam logic CFG_WIDTH = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [12:0] req_width;
        logic [12:0] req_height;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [11:0] place_x;
        logic [11:0] place_y;
    } res_t;

    typedef struct packed {
        logic [CoordBits-1:0] x;
        logic [CoordBits-1:0] y;
        logic [CoordBits-1:0] w;
        logic [CoordBits-1:0] h;
    } rect_t;

    // Classified request: zero-sized requests skip the search.
    typedef struct packed {
        logic trivial;
        logic [CoordBits-1:0] rw;
        logic [CoordBits-1:0] rh;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } qhead_t;
endpackage

// ----- rtl/core/guillotine_atlas_allocator.sv -----
// Channel  | Ports                          | Handshake
// request  | start, busy, req               | accepted when start && !busy
// result   | done, res                      | one cycle strobe, no back pressure
// config   | cfg_we, cfg_index, cfg_data    | written on any edge with cfg_we
// A request reads and checks the free entries in turn (S_RD, then S_CHK), and
// moves entries one at a time when the list shifts (S_SHUP or S_SHDN, then
// S_WR2). The result leaves when the search ends.
// Reset gives a 1024 x 1024 atlas; entry zero is written once reset is released.
// Two requests queue ahead of the search engine; busy rises when both wait.
`include "guillotine_atlas_allocator_defines.svh"
module guillotine_atlas_allocator
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  gaa_pkg::req_t req,
    output logic done,
    output gaa_pkg::res_t res,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [12:0] cfg_data
);
    gaa_pkg::qhead_t head;
    logic pop, idle;
    logic bad_corner;

    gaa_front u_front
    (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req),
        .busy(busy), .head(head), .pop(pop)
    );

    gaa_back u_back
    (
        .clk(clk), .rst_n(rst_n), .head(head), .pop(pop),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_val(cfg_data),
        .done(done), .res(res), .idle(idle)
    );

    assign bad_corner = (res.status != gaa_pkg::STAT_PLACED) &&
                        (res.place_x != '0 || res.place_y != '0);

    `GAA_NEVER(a_pop_empty, pop && !head.valid, "pop from empty queue")
    `GAA_NEVER(a_res_zero, done && bad_corner, "nonzero corner on failure")
    `GAA_NEVER(a_idle_done, idle && done && $past(idle), "result without work")
endmodule

// ----- rtl/core/gaa_front.sv -----
module gaa_front
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  gaa_pkg::req_t req,
    output logic busy,
    output gaa_pkg::qhead_t head,
    input  logic pop
);
    gaa_pkg::job_t q_reg [gaa_pkg::QDepth];
    logic [0:0] rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    logic push;
    gaa_pkg::job_t nj;

    assign busy = (cnt_reg == 2'(gaa_pkg::QDepth));
    assign push = start && !busy;
    assign head.valid = (cnt_reg != 2'd0);
    assign head.job = q_reg[rd_reg];

    always_comb
    begin
        nj.rw = req.req_width;
        nj.rh = req.req_height;
        nj.trivial = (req.req_width == '0) || (req.req_height == '0);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= nj;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ----- rtl/core/gaa_back.sv -----
module gaa_back
(
    input  logic clk,
    input  logic rst_n,
    input  gaa_pkg::qhead_t head,
    output logic pop,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [12:0] cfg_val,
    output logic done,
    output gaa_pkg::res_t res,
    output logic idle
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD    = 6'b000010,
        S_CHK   = 6'b000100,
        S_SHUP  = 6'b001000,
        S_SHDN  = 6'b010000,
        S_WR2   = 6'b100000
    } state_t;

    localparam int CB = gaa_pkg::CoordBits;
    localparam int IB = gaa_pkg::IdxBits;
    localparam int NB = gaa_pkg::CntBits;

    gaa_pkg::rect_t mem [gaa_pkg::FreeSlots];
    gaa_pkg::rect_t rdata_reg;
    state_t state_reg, state_next;
    logic [NB-1:0] cnt_reg, cnt_next, i_reg, i_next, k_reg, k_next;
    logic [CB-1:0] aw_reg, aw_next, ah_reg, ah_next, rw_reg, rh_reg;
    gaa_pkg::rect_t e_reg, e_next, p0_reg, p0_next, p1_reg, p1_next;
    logic done_reg, done_next;
    gaa_pkg::res_t res_reg, res_next;
    logic init_reg;
    logic rd_en;
    logic [IB-1:0] rd_addr;
    logic we;
    logic [IB-1:0] wa;
    gaa_pkg::rect_t wd;
    logic fits;
    logic [CB-1:0] dx, dy, cv;
    logic [1:0] np;

    assign done = done_reg;
    assign res = res_reg;
    assign idle = (state_reg == S_IDLE) && !head.valid;
    assign cv = (cfg_val > gaa_pkg::AtlasMax) ? gaa_pkg::AtlasMax : cfg_val;

    always_comb
    begin
        fits = (rdata_reg.w >= rw_reg) && (rdata_reg.h >= rh_reg);
        dx = rdata_reg.w - rw_reg;
        dy = rdata_reg.h - rh_reg;
        np = 2'd0;
        p0_next = p0_reg;
        p1_next = p1_reg;
        if (dx == '0 && dy == '0)
        begin
            np = 2'd0;
        end
        else if (dx > dy)
        begin
            if (dy != '0)
            begin
                np = 2'd2;
                p0_next = '{rdata_reg.x, rdata_reg.y + rh_reg, rw_reg, dy};
                p1_next = '{rdata_reg.x + rw_reg, rdata_reg.y, dx, rdata_reg.h};
            end
            else
            begin
                np = 2'd1;
                p0_next = '{rdata_reg.x + rw_reg, rdata_reg.y, dx, rdata_reg.h};
            end
        end
        else
        begin
            if (dx != '0)
            begin
                np = 2'd2;
                p0_next = '{rdata_reg.x + rw_reg, rdata_reg.y, dx, rh_reg};
                p1_next = '{rdata_reg.x, rdata_reg.y + rh_reg, rdata_reg.w, dy};
            end
            else
            begin
                np = 2'd1;
                p0_next = '{rdata_reg.x, rdata_reg.y + rh_reg, rdata_reg.w, dy};
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        i_next = i_reg;
        k_next = k_reg;
        aw_next = aw_reg;
        ah_next = ah_reg;
        e_next = e_reg;
        done_next = 1'b0;
        res_next = res_reg;
        pop = 1'b0;
        rd_en = 1'b0;
        rd_addr = i_reg[IB-1:0];
        we = 1'b0;
        wa = i_reg[IB-1:0];
        wd = p0_reg;
        // Entry zero holds the whole atlas once reset is released.
        if (init_reg)
        begin
            we = 1'b1;
            wa = '0;
            wd = '{'0, '0, aw_reg, ah_reg};
        end
        if (cfg_we)
        begin
            if (cfg_index == gaa_pkg::CFG_WIDTH)
            begin
                aw_next = cv;
            end
            else
            begin
                ah_next = cv;
            end
            we = 1'b1;
            wa = '0;
            wd = '{'0, '0, (cfg_index == gaa_pkg::CFG_WIDTH) ? cv : aw_reg,
                   (cfg_index == gaa_pkg::CFG_HEIGHT) ? cv : ah_reg};
            cnt_next = NB'(1);
            // A new atlas drops any list shift still running.
            if (state_reg != S_RD && state_reg != S_CHK)
            begin
                state_next = S_IDLE;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (head.valid)
                    begin
                        pop = 1'b1;
                        if (head.job.trivial)
                        begin
                            done_next = 1'b1;
                            res_next = '{gaa_pkg::STAT_NOFIT, '0, '0};
                        end
                        else
                        begin
                            i_next = '0;
                            state_next = S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    if (i_reg >= cnt_reg)
                    begin
                        done_next = 1'b1;
                        res_next = '{gaa_pkg::STAT_NOFIT, '0, '0};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                        state_next = S_CHK;
                    end
                end
                S_CHK:
                begin
                    if (!fits)
                    begin
                        i_next = i_reg + 1'b1;
                        state_next = S_RD;
                    end
                    else if (np == 2'd2 && cnt_reg >= NB'(gaa_pkg::FreeSlots))
                    begin
                        done_next = 1'b1;
                        res_next = '{gaa_pkg::STAT_FULL, '0, '0};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        done_next = 1'b1;
                        res_next = '{gaa_pkg::STAT_PLACED, rdata_reg.x[11:0],
                                     rdata_reg.y[11:0]};
                        e_next = rdata_reg;
                        if (np == 2'd1)
                        begin
                            we = 1'b1;
                            wd = p0_next;
                            state_next = S_IDLE;
                        end
                        else if (np == 2'd0)
                        begin
                            k_next = i_reg;
                            state_next = S_SHUP;
                        end
                        else
                        begin
                            k_next = cnt_reg;
                            state_next = S_SHDN;
                        end
                    end
                end
                S_SHUP:
                begin
                    // Pull entry k+1 down into k; the read data is registered and written in S_WR2.
                    if (k_reg + 1'b1 >= cnt_reg)
                    begin
                        cnt_next = cnt_reg - 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                        rd_addr = IB'(k_reg + 1'b1);
                        state_next = S_WR2;
                    end
                end
                S_SHDN:
                begin
                    if (k_reg > i_reg + 1'b1)
                    begin
                        rd_en = 1'b1;
                        rd_addr = IB'(k_reg - 1'b1);
                        state_next = S_WR2;
                    end
                    else
                    begin
                        we = 1'b1;
                        wa = IB'(i_reg + 1'b1);
                        wd = p1_reg;
                        cnt_next = cnt_reg + 1'b1;
                        state_next = S_WR2;
                        k_next = '0;
                    end
                end
                S_WR2:
                begin
                    // Finish one shift step, or write the first piece and stop.
                    we = 1'b1;
                    if (e_reg.w == '0 && k_reg == '0)
                    begin
                        wa = i_reg[IB-1:0];
                        wd = p0_reg;
                        state_next = S_IDLE;
                    end
                    else if (cnt_reg > i_reg + 1'b1 && k_reg >= i_reg + 1'b1 &&
                             p1_reg.w != '0 && k_reg != i_reg)
                    begin
                        wa = IB'(k_reg);
                        wd = rdata_reg;
                        k_next = k_reg - 1'b1;
                        state_next = S_SHDN;
                    end
                    else
                    begin
                        wa = IB'(k_reg);
                        wd = rdata_reg;
                        k_next = k_reg + 1'b1;
                        state_next = S_SHUP;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (state_reg == S_IDLE && head.valid)
        begin
            rw_reg <= head.job.rw;
            rh_reg <= head.job.rh;
        end
        p0_reg <= (state_reg == S_CHK) ? p0_next : p0_reg;
        p1_reg <= (state_reg == S_CHK) ? ((np == 2'd2) ? p1_next : '0) : p1_reg;
        e_reg <= (state_reg == S_CHK && np == 2'd2) ? '0 : e_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= NB'(1);
            i_reg <= '0;
            k_reg <= '0;
            aw_reg <= gaa_pkg::AtlasReset;
            ah_reg <= gaa_pkg::AtlasReset;
            done_reg <= 1'b0;
            res_reg <= '0;
            init_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            i_reg <= i_next;
            k_reg <= k_next;
            aw_reg <= aw_next;
            ah_reg <= ah_next;
            done_reg <= done_next;
            res_reg <= res_next;
            init_reg <= 1'b0;
        end
    end
endmodule
